/* rtl/particle_box_bounce_step_core_assert.svh */
// ----------------------------------------------------------------------------
// particle box bounce step assertion macros
// Concurrent assertion wrappers shared by the core; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_BOX_BOUNCE_STEP_CORE_ASSERT_SVH
`define PARTICLE_BOX_BOUNCE_STEP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbb assertion failed");

// next-cycle implication
`define PBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbb assertion failed");

`else

`define PBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/pbb_pkg.sv */
// ----------------------------------------------------------------------------
// pbb_pkg
// Widths, stage indexes, register codes and per-stage datapath functions.
// ----------------------------------------------------------------------------
package pbb_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int MAG_W   = 23;
    localparam int CFG_W   = 23;
    localparam int DIVR_W  = 16;
    localparam int RAD_W   = 22;
    localparam int DIAM_W  = RAD_W + 1;
    localparam int FRAC_W  = 8;

    // divider: 32 bit dividend, a few quotient bits per stage
    localparam int DIV_W      = 1 + MAG_W + FRAC_W;
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = DIV_W / STEP_BITS;
    localparam int SUM_W      = DIV_W + 2;

    // stage indexes: clamp, divider, sum, saturate, wall/output
    localparam int STG_SUM = DIV_STAGES + 1;
    localparam int STG_SAT = DIV_STAGES + 2;
    localparam int STG_OUT = DIV_STAGES + 3;
    localparam int NSTG    = DIV_STAGES + 4;

    // config register codes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_WIDTH,
        CFG_BOX_HEIGHT,
        CFG_SPEED_CAP,
        CFG_TICK_DIV
    } t_cfg_idx;

    localparam logic [CFG_W-1:0]  BOX_W_RST    = CFG_W'(65536);
    localparam logic [CFG_W-1:0]  BOX_H_RST    = CFG_W'(65536);
    localparam logic [CFG_W-1:0]  SPEED_CAP_RST = CFG_W'(2560);
    localparam logic [DIVR_W-1:0] TICK_DIV_RST = DIVR_W'(256);

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic                    sgn;
        logic [MAG_W-1:0]        mag;
        logic [DIVR_W-1:0]       rem;
        logic [DIV_W-1:0]        dq;
    } t_div_lane;

    typedef struct packed {
        t_div_lane        x;
        t_div_lane        y;
        logic [RAD_W-1:0] radius;
    } t_div_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    sgn;
        logic [MAG_W-1:0]        mag;
    } t_sum_lane;

    typedef struct packed {
        t_sum_lane        x;
        t_sum_lane        y;
        logic [RAD_W-1:0] radius;
    } t_sum_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic                    sgn;
        logic [MAG_W-1:0]        mag;
    } t_sat_lane;

    typedef struct packed {
        t_sat_lane        x;
        t_sat_lane        y;
        logic [RAD_W-1:0] radius;
    } t_sat_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] vel;
    } t_out_lane;

    // clamp |v| to the cap, keep the sign apart, load the dividend
    function automatic t_div_lane clamp_lane(logic signed [POS_W-1:0] pos,
                                             logic signed [POS_W-1:0] vel,
                                             logic [CFG_W-1:0] cap);
        t_div_lane       o;
        logic [POS_W-1:0] vabs;
        vabs = vel[POS_W-1] ? (~vel + POS_W'(1)) : vel;
        o.pos = pos;
        o.sgn = vel[POS_W-1];
        if (vabs > {1'b0, cap}) begin
            o.mag = cap;
        end else begin
            o.mag = vabs[MAG_W-1:0];
        end
        o.rem = '0;
        o.dq  = {1'b0, o.mag, {FRAC_W{1'b0}}};
        return o;
    endfunction

    // restoring division, STEP_BITS quotient bits
    function automatic t_div_lane div_step(t_div_lane a, logic [DIVR_W-1:0] d);
        t_div_lane         o;
        logic [DIVR_W:0]   r2;
        o = a;
        for (int i = 0; i < STEP_BITS; i++) begin
            r2   = {o.rem, o.dq[DIV_W-1]};
            o.dq = {o.dq[DIV_W-2:0], 1'b0};
            if (r2 >= {1'b0, d}) begin
                r2      = r2 - {1'b0, d};
                o.dq[0] = 1'b1;
            end
            o.rem = r2[DIVR_W-1:0];
        end
        return o;
    endfunction

    function automatic t_div_item div_item_step(t_div_item a, logic [DIVR_W-1:0] d);
        t_div_item o;
        o.x      = div_step(a.x, d);
        o.y      = div_step(a.y, d);
        o.radius = a.radius;
        return o;
    endfunction

    // position plus signed quotient
    function automatic t_sum_lane sum_lane(t_div_lane a);
        t_sum_lane        o;
        logic [SUM_W-1:0] q;
        q     = {2'b00, a.dq};
        o.sum = {{(SUM_W-POS_W){a.pos[POS_W-1]}}, a.pos}
              + (q ^ {SUM_W{a.sgn}}) + SUM_W'(a.sgn);
        o.sgn = a.sgn;
        o.mag = a.mag;
        return o;
    endfunction

    // saturate to the 24 bit signed range
    function automatic t_sat_lane sat_lane(t_sum_lane a);
        t_sat_lane o;
        logic      neg;
        logic      fits;
        neg  = a.sum[SUM_W-1];
        fits = neg ? (&a.sum[SUM_W-2:POS_W-1]) : !(|a.sum[SUM_W-2:POS_W-1]);
        if (fits) begin
            o.pos = a.sum[POS_W-1:0];
        end else if (neg) begin
            o.pos = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            o.pos = {1'b0, {(POS_W-1){1'b1}}};
        end
        o.sgn = a.sgn;
        o.mag = a.mag;
        return o;
    endfunction

    // wall test and reflection
    function automatic t_out_lane wall_lane(t_sat_lane a, logic [CFG_W-1:0] limit,
                                            logic [DIAM_W-1:0] diam);
        t_out_lane        o;
        logic [POS_W:0]   reach;
        logic [POS_W:0]   back;
        logic [POS_W-1:0] vm;
        logic             flip;
        reach = {1'b0, a.pos} + {2'b00, diam};
        back  = {2'b00, limit} - {2'b00, diam};
        if (a.pos[POS_W-1]) begin
            o.pos = '0;
            flip  = 1'b1;
        end else if (reach > {2'b00, limit}) begin
            o.pos = back[POS_W-1:0];
            flip  = 1'b1;
        end else begin
            o.pos = a.pos;
            flip  = 1'b0;
        end
        vm    = {1'b0, a.mag};
        o.vel = (a.sgn ^ flip) ? (~vm + POS_W'(1)) : vm;
        return o;
    endfunction

endpackage

/* rtl/particle_box_bounce_step_core.sv */
// ----------------------------------------------------------------------------
// particle_box_bounce_step_core
// One Euler step of a particle in a box with wall reflection, Q16.8 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one particle request:
//   position, velocity and radius. Output channel (o_out_valid / i_out_ready)
//   returns the new position and the clamped, possibly reflected velocity.
//   Exactly one result per request, in order.
//   Depth: 12 register stages, from the clamp stage to the output register.
//   Throughput: one request per cycle while o_in_ready is high. The depth
//   comes from the pipelined 32 bit quotient of velocity*256 / tick_divisor,
//   4 bits per stage over 8 stages, plus clamp, sum, saturate and wall
//   stages.
//   Each stage has its own valid bit and moves when the one after it is free,
//   so a stalled receiver holds the result in place while empty stages ahead
//   still fill; o_in_ready drops only when every stage holds a request.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   register defaults. The user must write registers through i_cfg_we only
//   while no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "particle_box_bounce_step_core_assert.svh"

module particle_box_bounce_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pbb_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [pbb_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [pbb_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [pbb_pkg::POS_W-1:0]    i_vel_x,
    input  logic signed [pbb_pkg::POS_W-1:0]    i_vel_y,
    input  logic [pbb_pkg::RAD_W-1:0]           i_radius,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pbb_pkg::POS_W-1:0]    o_new_pos_x,
    output logic signed [pbb_pkg::POS_W-1:0]    o_new_pos_y,
    output logic signed [pbb_pkg::POS_W-1:0]    o_new_vel_x,
    output logic signed [pbb_pkg::POS_W-1:0]    o_new_vel_y
);
    import pbb_pkg::*;

    logic [CFG_W-1:0]  r_box_w;
    logic [CFG_W-1:0]  r_box_h;
    logic [CFG_W-1:0]  r_speed_cap;
    logic [DIVR_W-1:0] r_tick_div;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   n_vld;
    logic [NSTG-1:0]   stg_en;

    t_div_item         r_div [0:DIV_STAGES];
    t_sum_item         r_sum;
    t_sat_item         r_sat;
    t_out_lane         r_out_x;
    t_out_lane         r_out_y;
    logic [DIAM_W-1:0] sat_diam;

    // config registers, zero divisor stored as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w     <= BOX_W_RST;
            r_box_h     <= BOX_H_RST;
            r_speed_cap <= SPEED_CAP_RST;
            r_tick_div  <= TICK_DIV_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BOX_WIDTH:  r_box_w     <= i_cfg_wdata;
                CFG_BOX_HEIGHT: r_box_h     <= i_cfg_wdata;
                CFG_SPEED_CAP:  r_speed_cap <= i_cfg_wdata;
                CFG_TICK_DIV: begin
                    if (i_cfg_wdata[DIVR_W-1:0] == '0) begin
                        r_tick_div <= DIVR_W'(1);
                    end else begin
                        r_tick_div <= i_cfg_wdata[DIVR_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // per-stage enables, a stage moves when empty or when the next one moves
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = stg_en[0];
    assign o_out_valid = r_vld[STG_OUT];

    // clamp stage loads the dividends, divider stages follow
    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_div[0].x      <= clamp_lane(i_pos_x, i_vel_x, r_speed_cap);
            r_div[0].y      <= clamp_lane(i_pos_y, i_vel_y, r_speed_cap);
            r_div[0].radius <= i_radius;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (stg_en[k]) begin
                r_div[k] <= div_item_step(r_div[k-1], r_tick_div);
            end
        end
    end

    // displacement add
    always_ff @(posedge i_clk) begin
        if (stg_en[STG_SUM]) begin
            r_sum.x      <= sum_lane(r_div[DIV_STAGES].x);
            r_sum.y      <= sum_lane(r_div[DIV_STAGES].y);
            r_sum.radius <= r_div[DIV_STAGES].radius;
        end
    end

    // saturation
    always_ff @(posedge i_clk) begin
        if (stg_en[STG_SAT]) begin
            r_sat.x      <= sat_lane(r_sum.x);
            r_sat.y      <= sat_lane(r_sum.y);
            r_sat.radius <= r_sum.radius;
        end
    end

    // wall test into the output register
    assign sat_diam = {r_sat.radius, 1'b0};

    always_ff @(posedge i_clk) begin
        if (stg_en[STG_OUT]) begin
            r_out_x <= wall_lane(r_sat.x, r_box_w, sat_diam);
            r_out_y <= wall_lane(r_sat.y, r_box_h, sat_diam);
        end
    end

    assign o_new_pos_x = r_out_x.pos;
    assign o_new_pos_y = r_out_y.pos;
    assign o_new_vel_x = r_out_x.vel;
    assign o_new_vel_y = r_out_y.vel;

    // input blocked only with every stage full
    `PBB_ASSERT_IMPL(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready, &r_vld)
    // a full pipeline with a stalled receiver stays full
    `PBB_ASSERT_NEXT(a_blocked_holds, i_clk, i_rst_n, !o_in_ready && !i_out_ready, &r_vld)
    // a taken result with nothing behind it leaves the output empty
    `PBB_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !r_vld[STG_SAT], !o_out_valid)

endmodule
